// ===== sv/pru_pkg.sv =====
// Shared types and constants for the pixel replication upscaler.
package pru_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int SCALE_W           = 7;
    localparam int SRC_WIDTH_W       = 11;
    localparam int CFG_DATA_W        = 11;
    localparam int CFG_INDEX_W       = 1;
    localparam int PIXEL_W           = 24;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCALE        = 1'b0,
        REG_SOURCE_WIDTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_REJECTED  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                  operation;
        logic [PIXEL_W-1:0]   pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]   pixel_out;
        status_t              status;
        logic                 row_end;
        logic [1:0]           pad_bytes;
        logic                 group_end;
    } out_item_t;

    typedef struct packed {
        status_t              status;
        logic                 row_end;
        logic [1:0]           pad_bytes;
        logic                 group_end;
    } out_ctrl_t;

endpackage

// ===== sv/pixel_replication_upscaler_unit.sv =====
// Top level of the pixel replication upscaler: line store, row sequencer and output register.
// Takes one transaction per cycle, pushes and pulls alike, unless stalled; the result appears
// on m_data in the cycle after acceptance. A push yields a rejected status while emitting,
// else none. The rate is set by the single line store, which takes one write (push) or one
// read (pull) per cycle into a registered read port feeding the output register. Pushes fill
// the store up to source_width pixels; then each pull gives one widened pixel, each row
// repeated scale times, row_end and pad_bytes on a row's last pixel, group_end on a group's.
// Writing a register abandons the row in progress; write only while the block is idle.
module pixel_replication_upscaler_unit
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    localparam int IDXW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNTW = $clog2(MAX_WIDTH + 1);

    logic [PIXEL_W-1:0]     line_store [MAX_WIDTH];

    logic [SCALE_W-1:0]     scale_reg;
    logic [SRC_WIDTH_W-1:0] source_width_reg;
    logic [CNTW-1:0]        fill_count_reg, fill_count_next;
    logic                   emitting_reg, emitting_next;
    logic [IDXW-1:0]        source_index_reg, source_index_next;
    logic [SCALE_W-1:0]     across_count_reg, across_count_next;
    logic [SCALE_W-1:0]     down_count_reg, down_count_next;

    logic                   out_valid_reg;
    out_ctrl_t              out_ctrl_reg, out_ctrl_next;
    logic [PIXEL_W-1:0]     rd_data_reg;

    logic [SCALE_W-1:0]     s_eff;
    logic [CNTW-1:0]        w_eff;
    logic [CNTW-1:0]        w_last;
    logic [31:0]            sw_ext;
    logic                   accept;
    logic                   wr_en, rd_en;
    logic [IDXW-1:0]        rd_addr;
    logic [CNTW-1:0]        idx;
    logic [SCALE_W:0]       across_inc, down_inc;
    logic [CNTW-1:0]        src_inc, fill_inc;
    logic                   re, ge;
    logic [3:0]             pad_prod;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    assign m_data.pixel_out = (out_ctrl_reg.status == ST_PIXEL) ? rd_data_reg : '0;
    assign m_data.status    = out_ctrl_reg.status;
    assign m_data.row_end   = out_ctrl_reg.row_end;
    assign m_data.pad_bytes = out_ctrl_reg.pad_bytes;
    assign m_data.group_end = out_ctrl_reg.group_end;

    // effective register values
    assign sw_ext = 32'(source_width_reg);
    always_comb begin
        if (scale_reg == '0) begin
            s_eff = SCALE_W'(1);
        end else if (scale_reg > SCALE_MAX) begin
            s_eff = SCALE_MAX;
        end else begin
            s_eff = scale_reg;
        end
        if (sw_ext == 32'd0) begin
            w_eff = CNTW'(1);
        end else if (sw_ext > 32'(MAX_WIDTH)) begin
            w_eff = CNTW'(MAX_WIDTH);
        end else begin
            w_eff = CNTW'(sw_ext);
        end
    end

    assign w_last     = w_eff - CNTW'(1);
    assign across_inc = {1'b0, across_count_reg} + (SCALE_W+1)'(1);
    assign down_inc   = {1'b0, down_count_reg} + (SCALE_W+1)'(1);
    assign src_inc    = CNTW'(source_index_reg) + CNTW'(1);
    assign fill_inc   = fill_count_reg + CNTW'(1);
    assign idx        = (CNTW'(source_index_reg) < w_eff) ? CNTW'(source_index_reg) : w_last;
    assign re         = (idx == w_last) && (across_inc >= {1'b0, s_eff});
    assign ge         = re && (down_inc >= {1'b0, s_eff});
    // (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4
    assign pad_prod   = 4'(w_eff[1:0]) * 4'(s_eff[1:0]);

    always_comb begin
        fill_count_next   = fill_count_reg;
        emitting_next     = emitting_reg;
        source_index_next = source_index_reg;
        across_count_next = across_count_reg;
        down_count_next   = down_count_reg;
        out_ctrl_next     = '0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = idx[IDXW-1:0];

        if (s_data.operation == OP_PUSH) begin
            if (emitting_reg) begin
                out_ctrl_next.status = ST_REJECTED;
            end else begin
                if (fill_count_reg < w_eff) begin
                    wr_en           = accept;
                    fill_count_next = fill_inc;
                end
                if (fill_count_next >= w_eff) begin
                    emitting_next     = 1'b1;
                    source_index_next = '0;
                    across_count_next = '0;
                    down_count_next   = '0;
                end
            end
        end else if (!emitting_reg) begin
            out_ctrl_next.status = ST_NOT_READY;
        end else begin
            rd_en                   = accept;
            out_ctrl_next.status    = ST_PIXEL;
            out_ctrl_next.row_end   = re;
            out_ctrl_next.group_end = ge;
            out_ctrl_next.pad_bytes = re ? pad_prod[1:0] : 2'd0;
            across_count_next       = across_inc[SCALE_W-1:0];
            if (across_inc >= {1'b0, s_eff}) begin
                across_count_next = '0;
                source_index_next = src_inc[IDXW-1:0];
                if (src_inc >= w_eff) begin
                    source_index_next = '0;
                    down_count_next   = down_inc[SCALE_W-1:0];
                    if (down_inc >= {1'b0, s_eff}) begin
                        fill_count_next   = '0;
                        emitting_next     = 1'b0;
                        down_count_next   = '0;
                    end
                end
            end
        end
    end

    // line store: one write or one registered read per cycle while transactions are accepted
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store[fill_count_reg[IDXW-1:0]] <= s_data.pixel_in;
        end
        if (rd_en) begin
            rd_data_reg <= line_store[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_ctrl_reg <= out_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg        <= SCALE_W'(1);
            source_width_reg <= SRC_WIDTH_W'(1);
            fill_count_reg   <= '0;
            emitting_reg     <= 1'b0;
            source_index_reg <= '0;
            across_count_reg <= '0;
            down_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                out_valid_reg <= !(s_data.operation == OP_PUSH && !emitting_reg);
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SCALE: begin
                        scale_reg <= cfg_wdata[SCALE_W-1:0];
                    end
                    REG_SOURCE_WIDTH: begin
                        source_width_reg <= cfg_wdata[SRC_WIDTH_W-1:0];
                    end
                    default: begin
                    end
                endcase
                fill_count_reg   <= '0;
                emitting_reg     <= 1'b0;
                source_index_reg <= '0;
                across_count_reg <= '0;
                down_count_reg   <= '0;
            end else if (accept) begin
                fill_count_reg   <= fill_count_next;
                emitting_reg     <= emitting_next;
                source_index_reg <= source_index_next;
                across_count_reg <= across_count_next;
                down_count_reg   <= down_count_next;
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the pixel replication upscaler unit.
`timescale 1ns / 1ps

module tb;
    import pru_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH_DEFAULT;
    localparam int IDLE_LIMIT  = 5000;
    localparam int ITEM_BUDGET = 800;
    localparam int FILL_CAP    = 64;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        cfg_reg_t         reg_idx;
        logic [10:0]      reg_val;
        op_t              op;
        logic [23:0]      pix;
        bit               typed;
        bit               t_has;
        out_item_t        t_exp;
    } dir_row_t;

    localparam out_item_t NO_RES   = '0;
    localparam out_item_t NOT_RDY  = '{pixel_out: 24'h0, status: ST_NOT_READY,
                                       row_end: 1'b0, pad_bytes: 2'd0, group_end: 1'b0};
    localparam out_item_t REJECT   = '{pixel_out: 24'h0, status: ST_REJECTED,
                                       row_end: 1'b0, pad_bytes: 2'd0, group_end: 1'b0};
    localparam out_item_t WHITE_1X = '{pixel_out: 24'hFFFFFF, status: ST_PIXEL,
                                       row_end: 1'b1, pad_bytes: 2'd1, group_end: 1'b1};

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;

    // row-level expectation carried alongside the driven transaction
    bit                     drv_typed = 1'b0;
    bit                     drv_has = 1'b0;
    out_item_t              drv_exp = '0;

    // predictor state
    logic [23:0]            row_pixels [STORE_DEPTH];
    int unsigned            fill_count = 0;
    bit                     emitting = 1'b0;
    int unsigned            src_idx = 0;
    int unsigned            across = 0;
    int unsigned            down = 0;
    logic [6:0]             cfg_scale = 7'd1;
    logic [10:0]            cfg_width = 11'd1;

    out_item_t              upscaled_due [$];
    int                     err_count = 0;
    int                     items_sent = 0;
    int                     burst_left = 0;
    int                     idle_cycles = 0;
    int                     stall_mode = 0;
    int                     stall_left = 0;
    int unsigned            tick = 0;

    dir_row_t dir_rows [30] = '{
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 1, 1, NOT_RDY},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'hFFFFFF, 1, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h000000, 1, 1, REJECT},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 1, 1, WHITE_1X},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 1, 1, NOT_RDY},
        '{ROW_WRITE, REG_SCALE,        11'd0,    OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_WRITE, REG_SOURCE_WIDTH, 11'd3,    OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h123456, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'hA5A5A5, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h5A5A5A, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'hFFFFFF, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_WRITE, REG_SCALE,        11'd127,  OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_WRITE, REG_SOURCE_WIDTH, 11'd0,    OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h800000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h7FFFFF, 1, 1, REJECT},
        '{ROW_WRITE, REG_SCALE,        11'd2,    OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_WRITE, REG_SOURCE_WIDTH, 11'd2047, OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h000001, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 1, 1, NOT_RDY},
        '{ROW_WRITE, REG_SOURCE_WIDTH, 11'd2,    OP_PUSH, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'h0F0F0F, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PUSH, 24'hF0F0F0, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES},
        '{ROW_ITEM,  REG_SCALE,        11'd0,    OP_PULL, 24'h000000, 0, 0, NO_RES}
    };

    pixel_replication_upscaler_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned eff_scale();
        if (cfg_scale == 7'd0) return 1;
        if (cfg_scale > SCALE_MAX) return int'(SCALE_MAX);
        return int'(cfg_scale);
    endfunction

    function automatic int unsigned eff_width();
        if (cfg_width == 11'd0) return 1;
        if (cfg_width > 11'(STORE_DEPTH)) return STORE_DEPTH;
        return int'(cfg_width);
    endfunction

    function automatic void clear_row();
        fill_count = 0;
        emitting   = 1'b0;
        src_idx    = 0;
        across     = 0;
        down       = 0;
    endfunction

    function automatic void predict_upscale(input in_item_t it, output bit has_res,
                                            output out_item_t res);
        int unsigned w;
        int unsigned s;
        int unsigned idx;
        int unsigned m;
        bit          re;
        w = eff_width();
        s = eff_scale();
        res = '0;
        has_res = 1'b0;
        if (it.operation == OP_PUSH) begin
            if (emitting) begin
                has_res = 1'b1;
                res.status = ST_REJECTED;
                return;
            end
            if (fill_count < w) begin
                row_pixels[fill_count] = it.pixel_in;
                fill_count++;
            end
            if (fill_count >= w) begin
                emitting = 1'b1;
                src_idx  = 0;
                across   = 0;
                down     = 0;
            end
        end else if (!emitting) begin
            has_res = 1'b1;
            res.status = ST_NOT_READY;
        end else begin
            has_res = 1'b1;
            idx = (src_idx < w) ? src_idx : w - 1;
            re  = (idx == w - 1) && (across + 1 >= s);
            res.pixel_out = row_pixels[idx];
            res.status    = ST_PIXEL;
            res.row_end   = re;
            res.group_end = re && (down + 1 >= s);
            if (re) begin
                m = ((w % 4) * (s % 4)) % 4;
                res.pad_bytes = 2'((4 - (3 * m) % 4) % 4);
            end
            across++;
            if (across >= s) begin
                across = 0;
                src_idx++;
                if (src_idx >= w) begin
                    src_idx = 0;
                    down++;
                    if (down >= s) clear_row();
                end
            end
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic send_item(input op_t op, input logic [23:0] pix, input bit typed,
                             input bit t_has, input out_item_t t_exp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        if ($urandom_range(0, 199) == 0 && upscaled_due.size() != 0) begin
            s_valid <= 1'b0;
            while (upscaled_due.size() != 0) @(posedge aclk);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_data    <= '{operation: op, pixel_in: pix};
        drv_typed <= typed;
        drv_has   <= t_has;
        drv_exp   <= t_exp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(op_t'($urandom_range(0, 1)), 24'($urandom()), 1'b0, 1'b0, NO_RES);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [10:0] val);
        s_valid <= 1'b0;
        while (upscaled_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_SCALE) cfg_scale = val[6:0];
        else cfg_width = val;
        clear_row();
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [6:0] sc, input logic [10:0] wd, input int rows,
                             input int noise, input bit full);
        int unsigned w;
        int unsigned s;
        int unsigned total;
        int unsigned fill;
        write_reg(REG_SCALE, {4'($urandom()), sc});
        write_reg(REG_SOURCE_WIDTH, wd);
        w = eff_width();
        s = eff_scale();
        // very wide rows are only part filled, to keep the run short
        fill = (w > FILL_CAP) ? $urandom_range(1, FILL_CAP) : w;
        for (int r = 0; r < rows; r++) begin
            for (int i = 0; i < fill; i++) begin
                if ($urandom_range(0, 99) < noise) send_noise();
                send_item(OP_PUSH, 24'($urandom()), 1'b0, 1'b0, NO_RES);
            end
            if (fill < w) begin
                send_item(OP_PULL, 24'($urandom()), 1'b0, 1'b0, NO_RES);
                break;
            end
            total = w * s * s;
            // cut the emission short: broken sequence, or too long to finish
            if (!full && (total > 400 || (r == rows - 1 && $urandom_range(0, 3) == 0)))
                total = $urandom_range(1, (total > 400) ? 400 : total);
            for (int i = 0; i < total; i++) begin
                if ($urandom_range(0, 99) < noise) send_noise();
                send_item(OP_PULL, 24'($urandom()), 1'b0, 1'b0, NO_RES);
            end
            if (total < w * s * s) break;
        end
    endtask

    // predictor runs on every accepted input transaction
    always @(posedge aclk) begin : intake
        bit        has;
        out_item_t res;
        if (aresetn && s_valid && s_ready) begin
            predict_upscale(s_data, has, res);
            if (drv_typed) begin
                has = drv_has;
                res = drv_exp;
            end
            if (has) upscaled_due.push_back(res);
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (upscaled_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_data);
                err_count++;
            end else begin
                want = upscaled_due.pop_front();
                check_field("pixel_out", want.pixel_out, m_data.pixel_out);
                check_field("status", want.status, m_data.status);
                check_field("row_end", want.row_end, m_data.row_end);
                check_field("pad_bytes", want.pad_bytes, m_data.pad_bytes);
                check_field("group_end", want.group_end, m_data.group_end);
            end
        end
    end

    // receiver stalls: always ready, random, or one cycle in three
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        tick++;
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= (tick % 3 == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int         k;
        logic [6:0] sc;
        logic [10:0] wd;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                send_item(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].typed,
                          dir_rows[i].t_has, dir_rows[i].t_exp);
        end

        // largest scale, emission cut short
        run_phase(7'd100, 11'd1, 1, 0, 1'b0);

        while (items_sent < ITEM_BUDGET) begin
            k = $urandom_range(0, 9);
            if (k == 0) sc = 7'd0;
            else if (k == 1) sc = 7'($urandom_range(101, 127));
            else sc = 7'($urandom_range(1, 4));
            k = $urandom_range(0, 19);
            if (k == 0) wd = 11'd0;
            else if (k == 1) wd = 11'($urandom_range(1025, 2047));
            else if (k < 4) wd = 11'($urandom_range(7, 40));
            else wd = 11'($urandom_range(1, 6));
            run_phase(sc, wd, $urandom_range(1, 3), $urandom_range(0, 2) * 10, 1'b0);
        end

        s_valid <= 1'b0;
        while (upscaled_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0 && upscaled_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
